// ----- design/shape_bucket_batch_planner_defines.svh -----
// assertion macros used by the planner back sequencer
`ifndef SHAPE_BUCKET_BATCH_PLANNER_DEFINES_SVH
`define SHAPE_BUCKET_BATCH_PLANNER_DEFINES_SVH

// plain property checked on every rising clock edge outside reset
`define SBBP_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication from an antecedent to a same-cycle consequent
`define SBBP_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- design/sbbp_pkg.sv -----
package sbbp_pkg;

  localparam int unsigned DimBits    = 16;
  localparam int unsigned BktBits    = 17;
  localparam int unsigned IdxBits    = 24;
  localparam int unsigned CellBits   = 38;
  localparam int unsigned TotBits    = 6;
  localparam int unsigned MaxBatch   = 32;
  localparam int unsigned PtrBits    = 5;
  localparam int unsigned FillBits   = 6;
  localparam int unsigned RowQuantum = 64;
  localparam int unsigned ColQuantum = 256;

  typedef struct packed {
    logic                 err;
    logic                 flush_before;
    logic                 flush_after;
    logic [DimBits-1:0]   row;
    logic [DimBits-1:0]   col;
    logic [BktBits-1:0]   bkt_rows;
    logic [BktBits-1:0]   bkt_cols;
    logic [IdxBits-1:0]   idx;
  } cmd_t;

  // quanta are powers of two, so rounding up is an add and a mask
  function automatic logic [BktBits-1:0] round_rows(input logic [DimBits-1:0] v);
    logic [BktBits-1:0] s;
    s = {1'b0, v} + BktBits'(RowQuantum - 1);
    return s & ~BktBits'(RowQuantum - 1);
  endfunction

  function automatic logic [BktBits-1:0] round_cols(input logic [DimBits-1:0] v);
    logic [BktBits-1:0] s;
    s = {1'b0, v} + BktBits'(ColQuantum - 1);
    return s & ~BktBits'(ColQuantum - 1);
  endfunction

endpackage

// ----- design/sbbp_if.sv -----
interface sbbp_in_if;
  logic                          valid;
  logic                          ready;
  logic [sbbp_pkg::DimBits-1:0]  row_count;
  logic [sbbp_pkg::DimBits-1:0]  col_count;
  logic                          list_end;

  modport source (output valid, row_count, col_count, list_end, input ready);
  modport sink   (input valid, row_count, col_count, list_end, output ready);
endinterface

interface sbbp_out_if;
  logic                          valid;
  logic                          ready;
  logic [sbbp_pkg::IdxBits-1:0]  first_request;
  logic [sbbp_pkg::TotBits-1:0]  request_total;
  logic [sbbp_pkg::BktBits-1:0]  group_rows;
  logic [sbbp_pkg::BktBits-1:0]  group_cols;
  logic [sbbp_pkg::CellBits-1:0] real_cells;
  logic [sbbp_pkg::CellBits-1:0] charged_cells;
  logic                          is_padded_batch;
  logic [sbbp_pkg::CellBits-1:0] refused_padding;
  logic                          error_flag;
  logic                          run_last;

  modport source (output valid, first_request, request_total, group_rows, group_cols,
                  real_cells, charged_cells, is_padded_batch, refused_padding,
                  error_flag, run_last, input ready);
  modport sink   (input valid, first_request, request_total, group_rows, group_cols,
                  real_cells, charged_cells, is_padded_batch, refused_padding,
                  error_flag, run_last, output ready);
endinterface

// ----- design/sbbp_front.sv -----
module sbbp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  sbbp_in_if.sink         in_i,
  output sbbp_pkg::cmd_t  cmd_o,
  output logic            cmd_valid_o,
  input  logic            cmd_ready_i
);

  logic [sbbp_pkg::IdxBits:0]     idx_q;
  logic                           skip_q;
  logic [sbbp_pkg::FillBits-1:0]  fill_q;
  logic [sbbp_pkg::BktBits-1:0]   bkr_q, bkc_q;

  logic                           accept, bad, fb, fa;
  logic [sbbp_pkg::BktBits-1:0]   br, bc;
  logic [sbbp_pkg::FillBits-1:0]  new_fill;

  assign in_i.ready = cmd_ready_i;
  assign accept     = in_i.valid && cmd_ready_i;

  always_comb begin
    br       = sbbp_pkg::round_rows(in_i.row_count);
    bc       = sbbp_pkg::round_cols(in_i.col_count);
    // index bit 24, above the 24-bit index, set means the list ran past its last index
    bad      = (in_i.row_count == '0) || (in_i.col_count == '0) || idx_q[sbbp_pkg::IdxBits];
    fb       = (fill_q != '0) && ((br != bkr_q) || (bc != bkc_q));
    new_fill = (fb ? '0 : fill_q) + sbbp_pkg::FillBits'(1);
    fa       = (new_fill >= sbbp_pkg::FillBits'(sbbp_pkg::MaxBatch)) || in_i.list_end;

    cmd_o.err          = bad;
    cmd_o.flush_before = fb && !bad;
    cmd_o.flush_after  = fa && !bad;
    cmd_o.row          = in_i.row_count;
    cmd_o.col          = in_i.col_count;
    cmd_o.bkt_rows     = br;
    cmd_o.bkt_cols     = bc;
    cmd_o.idx          = idx_q[sbbp_pkg::IdxBits-1:0];
    cmd_valid_o        = in_i.valid && !skip_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      skip_q <= 1'b0;
      fill_q <= '0;
      bkr_q  <= '0;
      bkc_q  <= '0;
    end else if (accept) begin
      if (skip_q) begin
        if (in_i.list_end) begin
          skip_q <= 1'b0;
          idx_q  <= '0;
          fill_q <= '0;
        end
      end else if (bad) begin
        fill_q <= '0;
        if (in_i.list_end) idx_q <= '0;
        else skip_q <= 1'b1;
      end else begin
        bkr_q  <= br;
        bkc_q  <= bc;
        fill_q <= fa ? '0 : new_fill;
        idx_q  <= in_i.list_end ? '0 : idx_q + (sbbp_pkg::IdxBits+1)'(1);
      end
    end
  end

endmodule

// ----- design/sbbp_fifo.sv -----
module sbbp_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sbbp_pkg::cmd_t  push_data_i,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  output sbbp_pkg::cmd_t  pop_data_o,
  output logic            pop_valid_o,
  input  logic            pop_ready_i
);

  localparam int unsigned Depth = 4;

  sbbp_pkg::cmd_t  mem_q [Depth];
  logic [1:0]      wr_q, rd_q;
  logic [2:0]      cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != 3'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 2'd1;
      if (pop)  rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + 3'(push) - 3'(pop);
    end
  end

endmodule

// ----- design/sbbp_back.sv -----
`include "shape_bucket_batch_planner_defines.svh"

module sbbp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sbbp_pkg::cmd_t  cmd_i,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  sbbp_out_if.source      out_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_APP_MUL, S_APP_ADD, S_FL_DEC, S_EMIT_BATCH,
    S_GRP_START, S_GRP_SCAN, S_EMIT_GRP, S_EMIT_ERR
  } state_e;

  localparam int unsigned CB = sbbp_pkg::CellBits;

  state_e                         state_q;
  sbbp_pkg::cmd_t                 cmd_q;
  logic                           after_q, first_q, ovalid_q;
  logic [sbbp_pkg::FillBits-1:0]  fill_q, s_q, j_q;
  logic [sbbp_pkg::IdxBits-1:0]   start_q;
  logic [sbbp_pkg::BktBits-1:0]   bkr_q, bkc_q;
  logic [2*sbbp_pkg::BktBits-1:0] bprod_q;
  logic [2*sbbp_pkg::DimBits-1:0] prod_q;
  logic [CB-1:0]                  real_q, pad_q, refused_q, cells_q;
  logic [sbbp_pkg::DimBits-1:0]   rs_q, cs_q;
  logic [sbbp_pkg::DimBits-1:0]   mem_rows_q [sbbp_pkg::MaxBatch];
  logic [sbbp_pkg::DimBits-1:0]   mem_cols_q [sbbp_pkg::MaxBatch];

  logic [CB-1:0]                  diff, cells_sum;
  logic [CB+3:0]                  ten_diff;
  logic                           pad_gt, multi, batch_ok, slot_free, last_here;
  logic                           grp_end, match, emit_fire;
  logic [sbbp_pkg::PtrBits-1:0]   rd_addr;
  logic [sbbp_pkg::DimBits-1:0]   rd_row, rd_col;

  always_comb begin
    diff      = pad_q - real_q;
    pad_gt    = pad_q > real_q;
    multi     = fill_q >= sbbp_pkg::FillBits'(2);
    // padded <= real + real/10 is the same as 10*(padded-real) <= real
    ten_diff  = {diff, 3'b000} + {2'b00, diff, 1'b0};
    batch_ok  = multi && (!pad_gt || (ten_diff <= {4'b0000, real_q}));
    rd_addr   = (state_q == S_GRP_START) ? s_q[sbbp_pkg::PtrBits-1:0]
                                         : j_q[sbbp_pkg::PtrBits-1:0];
    rd_row    = mem_rows_q[rd_addr];
    rd_col    = mem_cols_q[rd_addr];
    slot_free = !ovalid_q || out_o.ready;
    emit_fire = slot_free && ((state_q == S_EMIT_BATCH) || (state_q == S_EMIT_GRP) ||
                              (state_q == S_EMIT_ERR));
    last_here = after_q || !cmd_q.flush_after;
    grp_end   = (j_q == fill_q);
    match     = (j_q < fill_q) && (rd_row == rs_q) && (rd_col == cs_q);
    cells_sum = cells_q + CB'(prod_q);
  end

  assign cmd_ready_o = (state_q == S_IDLE);
  assign out_o.valid = ovalid_q;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
      fill_q   <= '0;
      after_q  <= 1'b0;
      first_q  <= 1'b0;
      s_q      <= '0;
      j_q      <= '0;
    end else begin
      if (emit_fire)        ovalid_q <= 1'b1;
      else if (out_o.ready) ovalid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            after_q <= 1'b0;
            if (cmd_i.err)               state_q <= S_EMIT_ERR;
            else if (cmd_i.flush_before) state_q <= S_FL_DEC;
            else                         state_q <= S_APP_MUL;
          end
        end
        S_APP_MUL: state_q <= S_APP_ADD;
        S_APP_ADD: begin
          fill_q <= fill_q + sbbp_pkg::FillBits'(1);
          if (cmd_q.flush_after) begin
            after_q <= 1'b1;
            state_q <= S_FL_DEC;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_FL_DEC: begin
          s_q     <= '0;
          first_q <= 1'b1;
          state_q <= batch_ok ? S_EMIT_BATCH : S_GRP_START;
        end
        S_EMIT_BATCH: begin
          if (slot_free) begin
            fill_q   <= '0;
            state_q  <= after_q ? S_IDLE : S_APP_MUL;
          end
        end
        S_GRP_START: begin
          j_q     <= s_q + sbbp_pkg::FillBits'(1);
          state_q <= S_GRP_SCAN;
        end
        S_GRP_SCAN: begin
          if (match) j_q <= j_q + sbbp_pkg::FillBits'(1);
          else       state_q <= S_EMIT_GRP;
        end
        S_EMIT_GRP: begin
          if (slot_free) begin
            s_q      <= j_q;
            first_q  <= 1'b0;
            if (grp_end) begin
              fill_q  <= '0;
              state_q <= after_q ? S_IDLE : S_APP_MUL;
            end else begin
              state_q <= S_GRP_START;
            end
          end
        end
        S_EMIT_ERR: begin
          if (slot_free) begin
            fill_q   <= '0;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath and chunk buffer
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: if (cmd_valid_i) cmd_q <= cmd_i;
      S_APP_MUL: begin
        if (fill_q == '0) begin
          start_q <= cmd_q.idx;
          bkr_q   <= cmd_q.bkt_rows;
          bkc_q   <= cmd_q.bkt_cols;
          bprod_q <= cmd_q.bkt_rows * cmd_q.bkt_cols;
          real_q  <= '0;
          pad_q   <= '0;
        end
        mem_rows_q[fill_q[sbbp_pkg::PtrBits-1:0]] <= cmd_q.row;
        mem_cols_q[fill_q[sbbp_pkg::PtrBits-1:0]] <= cmd_q.col;
        prod_q <= cmd_q.row * cmd_q.col;
      end
      S_APP_ADD: begin
        real_q <= real_q + CB'(prod_q);
        pad_q  <= pad_q + CB'(bprod_q);
      end
      S_FL_DEC: refused_q <= (multi && pad_gt) ? diff : '0;
      S_GRP_START: begin
        rs_q    <= rd_row;
        cs_q    <= rd_col;
        prod_q  <= rd_row * rd_col;
        cells_q <= '0;
      end
      S_GRP_SCAN: if (match) cells_q <= cells_sum;
      S_EMIT_BATCH: begin
        if (slot_free) begin
          out_o.first_request   <= start_q;
          out_o.request_total   <= fill_q;
          out_o.group_rows      <= bkr_q;
          out_o.group_cols      <= bkc_q;
          out_o.real_cells      <= real_q;
          out_o.charged_cells   <= pad_q;
          out_o.is_padded_batch <= 1'b1;
          out_o.refused_padding <= '0;
          out_o.error_flag      <= 1'b0;
          out_o.run_last        <= last_here;
        end
      end
      S_EMIT_GRP: begin
        if (slot_free) begin
          out_o.first_request   <= start_q + sbbp_pkg::IdxBits'(s_q);
          out_o.request_total   <= j_q - s_q;
          out_o.group_rows      <= {1'b0, rs_q};
          out_o.group_cols      <= {1'b0, cs_q};
          out_o.real_cells      <= cells_sum;
          out_o.charged_cells   <= cells_sum;
          out_o.is_padded_batch <= 1'b0;
          out_o.refused_padding <= first_q ? refused_q : '0;
          out_o.error_flag      <= 1'b0;
          out_o.run_last        <= grp_end && last_here;
        end
      end
      S_EMIT_ERR: begin
        if (slot_free) begin
          out_o.first_request   <= '0;
          out_o.request_total   <= '0;
          out_o.group_rows      <= '0;
          out_o.group_cols      <= '0;
          out_o.real_cells      <= '0;
          out_o.charged_cells   <= '0;
          out_o.is_padded_batch <= 1'b0;
          out_o.refused_padding <= '0;
          out_o.error_flag      <= 1'b1;
          out_o.run_last        <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  `SBBP_CHECK(a_fill_bound, fill_q <= sbbp_pkg::FillBits'(sbbp_pkg::MaxBatch), "chunk overfilled")
  `SBBP_IMPLY(a_err_empty, ovalid_q && out_o.error_flag, out_o.request_total == '0 && out_o.run_last, "error word not clean")
  `SBBP_IMPLY(a_grp_nonempty, ovalid_q && !out_o.error_flag, out_o.request_total != '0, "empty group emitted")
  `SBBP_IMPLY(a_scan_inside, state_q == S_GRP_SCAN, j_q <= fill_q && j_q > s_q, "scan pointer outside chunk")

endmodule

// ----- design/shape_bucket_batch_planner.sv -----
// Shape bucket batch planner. Takes one job shape per word and emits padded batch groups,
// exact-shape groups or an error word, with run_last on the final word caused by a shape.
// A front stage classifies each shape against the open bucket and queues a command (four
// deep); a back sequencer owns the 32-entry chunk buffer. Appending a shape steps through
// accept, multiply and accumulate states. Flushing a chunk that batches steps through
// decide and emit; one that splits takes a decision step, then per exact group a start,
// a scan over the shapes in it and an emit. An error word is accepted, then emitted. The
// back sequencer takes a new command only when idle, so shapes wait in the queue while a
// chunk is appended or flushed. Results leave through a one-word output register.
module shape_bucket_batch_planner (
  input  logic        clk_i,
  input  logic        rst_ni,
  sbbp_in_if.sink     in_i,
  sbbp_out_if.source  out_o
);

  sbbp_pkg::cmd_t  push_data, pop_data;
  logic            push_valid, push_ready, pop_valid, pop_ready;

  sbbp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_o       (push_data),
    .cmd_valid_o (push_valid),
    .cmd_ready_i (push_ready)
  );

  sbbp_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (push_data),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .pop_data_o   (pop_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready)
  );

  sbbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (pop_data),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .out_o       (out_o)
  );

endmodule
